[rtl/bistbl_pkg.sv]
// Package for the bounded integer set table: command and status codes,
// field widths and the result record. No dependencies.
package bistbl_pkg;

  localparam int unsigned CapacityDefault = 16;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StatW   = 2;
  localparam int unsigned MatchW  = 4;
  localparam int unsigned CountW  = 5;

  typedef enum logic [CmdW-1:0] {
    CmdClear  = 2'd0,
    CmdInsert = 2'd1,
    CmdRemove = 2'd2,
    CmdSearch = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    StDone   = 2'd0,
    StFull   = 2'd1,
    StAbsent = 2'd2
  } status_e;

  typedef struct packed {
    status_e                  status;
    logic [MatchW-1:0]        match_index;
    logic [CountW-1:0]        entry_count;
    logic                     is_empty;
    logic signed [ValW-1:0]   min_value;
    logic signed [ValW-1:0]   max_value;
  } res_t;

endpackage

[rtl/bistbl_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module bistbl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

[rtl/bounded_integer_set_table_core.sv]
// Bounded integer set table: entry storage in a RAM, scan sequencer and
// result staging. Depends on bistbl_pkg and bistbl_ram.
//
//   The input channel (in_valid_i / in_stall_o) carries one transaction per
//   command: clear, insert, remove or search, with a signed 32-bit value.
//   The output channel (out_valid_o / out_stall_i) returns exactly one
//   result transaction per command: status, match index, entry count, empty
//   flag and the minimum and maximum held entries (-1 when empty).
//   Clear and insert complete in the accept cycle; the result goes into the
//   staging register and then the output register, and the input takes no
//   new transaction while it is staged. Remove and search scan the RAM
//   one entry per cycle, so the result is staged when the scan reaches the
//   last entry (a search stops at the first match), and the input stays
//   stalled until it has moved on to the output register.
//   Remove compacts the table in the same pass, writing each later entry one
//   slot down while it rebuilds minimum and maximum. A staging register sits
//   in front of the output register. When the receiver stalls, the output
//   register holds its transaction, the staged result waits behind it, and
//   the input stalls while anything is staged. Reset empties the table (count
//   zero, minimum and maximum -1) and drops pending results; RAM is undefined.
module bounded_integer_set_table_core #(
  parameter int unsigned Capacity = bistbl_pkg::CapacityDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [bistbl_pkg::CmdW-1:0]          command_i,
  input  logic signed [bistbl_pkg::ValW-1:0]   value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [bistbl_pkg::StatW-1:0]         status_o,
  output logic [bistbl_pkg::MatchW-1:0]        match_index_o,
  output logic [bistbl_pkg::CountW-1:0]        entry_count_o,
  output logic                                 is_empty_o,
  output logic signed [bistbl_pkg::ValW-1:0]   min_value_o,
  output logic signed [bistbl_pkg::ValW-1:0]   max_value_o
);

  import bistbl_pkg::*;

  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW = $clog2(Capacity + 1);

  typedef enum logic {
    Idle,
    Scan
  } state_e;

  // Sequencer state
  state_e                 state_q, state_d;
  logic [IdxW-1:0]        idx_q, idx_d;        // entry whose data is on rd_data
  logic                   found_q, found_d;
  logic [IdxW-1:0]        match_q, match_d;
  logic                   remove_q, remove_d;  // scan is a remove, else search
  logic signed [ValW-1:0] key_q, key_d;

  // Running minimum / maximum of the compacted table during a remove scan
  logic                   acc_any_q, acc_any_d;
  logic signed [ValW-1:0] acc_min_q, acc_min_d;
  logic signed [ValW-1:0] acc_max_q, acc_max_d;

  // Table summary
  logic [CntW-1:0]        count_q, count_d;
  logic signed [ValW-1:0] min_q, min_d;
  logic signed [ValW-1:0] max_q, max_d;

  // Result staging and output register
  logic                   res_pending_q, res_pending_d;
  res_t                   res_q, res_d;
  logic                   out_valid_q, out_valid_d;
  res_t                   out_q, out_d;

  // RAM port signals
  logic                   wr_en;
  logic [IdxW-1:0]        wr_addr;
  logic [ValW-1:0]        wr_data;
  logic [IdxW-1:0]        rd_addr;
  logic [ValW-1:0]        rd_data;

  // Helpers
  logic                   in_fire;
  logic                   emit;
  status_e                emit_status;
  logic [IdxW-1:0]        emit_match;
  logic signed [ValW-1:0] rd_val;
  logic                   hit;
  logic                   last;
  logic [31:0]            match_wide;
  logic [31:0]            count_wide;

  bistbl_ram #(
    .Width (ValW),
    .Depth (Capacity),
    .AddrW (IdxW)
  ) u_entries (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign in_stall_o = (state_q != Idle) || res_pending_q;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Fetch entry 0 on accept, then one entry ahead of the one being examined.
  assign rd_addr = (state_q == Idle) ? '0 : idx_q + IdxW'(1);

  assign rd_val = $signed(rd_data);
  assign hit    = !found_q && (rd_val == key_q);
  assign last   = (CntW'(idx_q) == count_q - CntW'(1));

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    found_d       = found_q;
    match_d       = match_q;
    remove_d      = remove_q;
    key_d         = key_q;
    acc_any_d     = acc_any_q;
    acc_min_d     = acc_min_q;
    acc_max_d     = acc_max_q;
    count_d       = count_q;
    min_d         = min_q;
    max_d         = max_q;
    res_pending_d = res_pending_q;
    res_d         = res_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;

    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = rd_data;
    emit        = 1'b0;
    emit_status = StDone;
    emit_match  = '0;

    // Advance the output register; drain staging into it when it frees up.
    if (res_pending_q && (!out_valid_q || !out_stall_i)) begin
      out_d         = res_q;
      out_valid_d   = 1'b1;
      res_pending_d = 1'b0;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      Idle: begin
        if (in_fire) begin
          case (cmd_e'(command_i))
            CmdClear: begin
              count_d = '0;
              min_d   = '1;
              max_d   = '1;
              emit    = 1'b1;
            end
            CmdInsert: begin
              emit = 1'b1;
              if (count_q < CntW'(Capacity)) begin
                wr_en   = 1'b1;
                wr_addr = count_q[IdxW-1:0];
                wr_data = value_i;
                count_d = count_q + CntW'(1);
                if (count_q == '0) begin
                  min_d = value_i;
                  max_d = value_i;
                end else begin
                  if (value_i < min_q) min_d = value_i;
                  if (value_i > max_q) max_d = value_i;
                end
              end else begin
                emit_status = StFull;
              end
            end
            default: begin
              // Remove or search: nothing to scan in an empty table.
              if (count_q == '0) begin
                emit        = 1'b1;
                emit_status = StAbsent;
              end else begin
                state_d   = Scan;
                idx_d     = '0;
                found_d   = 1'b0;
                match_d   = '0;
                remove_d  = (cmd_e'(command_i) == CmdRemove);
                key_d     = value_i;
                acc_any_d = 1'b0;
                acc_min_d = '0;
                acc_max_d = '0;
              end
            end
          endcase
        end
      end

      Scan: begin
        idx_d = idx_q + IdxW'(1);
        if (hit) begin
          found_d = 1'b1;
          match_d = idx_q;
        end else begin
          // Shift entries past the removed one down by one slot.
          if (found_q) begin
            wr_en   = 1'b1;
            wr_addr = idx_q - IdxW'(1);
            wr_data = rd_data;
          end
          acc_any_d = 1'b1;
          if (!acc_any_q || rd_val < acc_min_q) acc_min_d = rd_val;
          if (!acc_any_q || rd_val > acc_max_q) acc_max_d = rd_val;
        end

        if (hit && !remove_q) begin
          // Search hit: table unchanged, stop early.
          state_d    = Idle;
          emit       = 1'b1;
          emit_match = idx_q;
        end else if (last) begin
          state_d = Idle;
          emit    = 1'b1;
          if (hit || found_q) begin
            count_d    = count_q - CntW'(1);
            emit_match = hit ? idx_q : match_q;
            min_d      = acc_any_d ? acc_min_d : '1;
            max_d      = acc_any_d ? acc_max_d : '1;
          end else begin
            emit_status = StAbsent;
          end
        end
      end

      default: begin
        state_d = Idle;
      end
    endcase

    if (emit) begin
      res_pending_d     = 1'b1;
      res_d.status      = emit_status;
      res_d.match_index = match_wide[MatchW-1:0];
      res_d.entry_count = count_wide[CountW-1:0];
      res_d.is_empty    = (count_d == '0);
      res_d.min_value   = min_d;
      res_d.max_value   = max_d;
    end
  end

  assign match_wide = 32'(emit_match);
  assign count_wide = 32'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= Idle;
      idx_q         <= '0;
      found_q       <= 1'b0;
      match_q       <= '0;
      remove_q      <= 1'b0;
      key_q         <= '0;
      acc_any_q     <= 1'b0;
      acc_min_q     <= '0;
      acc_max_q     <= '0;
      count_q       <= '0;
      min_q         <= '1;
      max_q         <= '1;
      res_pending_q <= 1'b0;
      res_q         <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      found_q       <= found_d;
      match_q       <= match_d;
      remove_q      <= remove_d;
      key_q         <= key_d;
      acc_any_q     <= acc_any_d;
      acc_min_q     <= acc_min_d;
      acc_max_q     <= acc_max_d;
      count_q       <= count_d;
      min_q         <= min_d;
      max_q         <= max_d;
      res_pending_q <= res_pending_d;
      res_q         <= res_d;
      out_valid_q   <= out_valid_d;
      out_q         <= out_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign match_index_o = out_q.match_index;
  assign entry_count_o = out_q.entry_count;
  assign is_empty_o    = out_q.is_empty;
  assign min_value_o   = out_q.min_value;
  assign max_value_o   = out_q.max_value;

endmodule
